### hdl/dtm_pkg.sv
package dtm_pkg;

   localparam int unsigned MaxLayersDefault = 256;

   localparam int unsigned CostW   = 16;
   localparam int unsigned DispW   = 10;
   localparam int unsigned OffsetW = 9;
   localparam int unsigned DistW   = 8;
   localparam int unsigned CsrIdxW = 2;
   localparam int unsigned CsrW    = 9;

   localparam logic [CsrIdxW-1:0] CsrMinDisp       = 2'd0;
   localparam logic [CsrIdxW-1:0] CsrSeparation    = 2'd1;
   localparam logic [CsrIdxW-1:0] CsrMergeDistance = 2'd2;

   localparam logic signed [OffsetW-1:0] MinDispReset       = 9'sd0;
   localparam logic [DistW-1:0]          SeparationReset    = 8'd5;
   localparam logic [DistW-1:0]          MergeDistanceReset = 8'd1;

   typedef struct packed {
      logic signed [CostW-1:0] cost;
      logic                    last;
   } item_type;

   typedef struct packed {
      logic signed [DispW-1:0] disp_high;
      logic signed [DispW-1:0] disp_low;
   } result_type;

   typedef struct packed {
      logic [OffsetW-1:0] min_disp;
      logic [DistW-1:0]   separation;
      logic [DistW-1:0]   merge_distance;
   } cfg_type;

   function automatic logic [DistW-1:0] index_dist(input logic [DistW-1:0] a,
                                                   input logic [DistW-1:0] b);
      return (a > b) ? a - b : b - a;
   endfunction

endpackage

### hdl/disparity_two_minima_range_core.sv
// Channel | Direction | Ports                  | Contents
// req     | in        | tvalid tready tdata    | tdata[15:0] cost, tlast last_layer
// rsp     | out       | tvalid tready tdata    | tdata[9:0] disp_low, [19:10] disp_high
// csr     | in        | we index wdata         | 0 min_disp, 1 separation, 2 merge_distance
//
// One layer is taken per cycle unless rsp stalls. A layer waits in the input register,
// the best/second-best update runs from there, and the result of a last layer is
// registered on rsp as that layer leaves. The held pair is updated on each advance.
// Reset is synchronous; it clears the layer count, the pair and both valid flags and
// returns the configuration registers to their defaults.
// A stalled rsp holds the input register, and req_tready drops once it is full.
module disparity_two_minima_range_core #(
   parameter int unsigned MAX_LAYERS = dtm_pkg::MaxLayersDefault
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   input  logic [15:0]                  req_tdata,   // [15:0] cost
   input  logic                         req_tlast,
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   output logic [23:0]                  rsp_tdata,   // [9:0] disp_low, [19:10] disp_high
   input  logic                         csr_we,
   input  logic [dtm_pkg::CsrIdxW-1:0]  csr_index,
   input  logic [dtm_pkg::CsrW-1:0]     csr_wdata
);
   import dtm_pkg::*;

   logic       s1_valid_ff, s1_valid_in;
   item_type   s1_item_ff;
   logic       rsp_valid_ff, rsp_valid_in;
   result_type rsp_data_ff;
   cfg_type    cfg_ff;
   result_type result;
   logic       advance;

   // The input stage moves on whenever the output register is free or draining.
   assign advance    = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || advance;

   assign s1_valid_in = (req_tvalid && req_tready) || (s1_valid_ff && !advance);

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      if (advance && s1_item_ff.last) begin
         rsp_valid_in = 1'b1;
      end
   end

   dtm_select #(
      .MAX_LAYERS(MAX_LAYERS)
   ) u_select (
      .clock (clock),
      .reset (reset),
      .step  (advance),
      .item  (s1_item_ff),
      .cfg   (cfg_ff),
      .result(result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         s1_item_ff.cost <= req_tdata;
         s1_item_ff.last <= req_tlast;
      end
      if (advance && s1_item_ff.last) begin
         rsp_data_ff <= result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.min_disp       <= MinDispReset;
         cfg_ff.separation     <= SeparationReset;
         cfg_ff.merge_distance <= MergeDistanceReset;
      end else if (csr_we) begin
         case (csr_index)
            CsrMinDisp:       cfg_ff.min_disp       <= csr_wdata;
            CsrSeparation:    cfg_ff.separation     <= csr_wdata[DistW-1:0];
            CsrMergeDistance: cfg_ff.merge_distance <= csr_wdata[DistW-1:0];
            default: begin
            end
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0000, rsp_data_ff.disp_high, rsp_data_ff.disp_low};

   a_ready_low_only_when_full: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> s1_valid_ff)
      else $error("input stage refused a transaction while empty");

   a_last_gives_result: assert property (@(posedge clock) disable iff (reset)
      (advance && s1_item_ff.last) |=> rsp_tvalid)
      else $error("last layer did not produce a result");

   a_result_from_last: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(s1_valid_ff && s1_item_ff.last))
      else $error("result appeared without a last layer");

endmodule

### hdl/dtm_select.sv
module dtm_select #(
   parameter int unsigned MAX_LAYERS = dtm_pkg::MaxLayersDefault
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                step,
   input  dtm_pkg::item_type   item,
   input  dtm_pkg::cfg_type    cfg,
   output dtm_pkg::result_type result
);
   import dtm_pkg::*;

   localparam int unsigned LayerW = (MAX_LAYERS > 2) ? $clog2(MAX_LAYERS) : 1;
   localparam logic [LayerW-1:0] LastLayer = LayerW'(MAX_LAYERS - 1);

   logic [LayerW-1:0]       layer_ff, layer_in;
   logic [LayerW-1:0]       best_layer_ff, best_layer_in;
   logic [LayerW-1:0]       second_layer_ff, second_layer_in;
   logic signed [CostW-1:0] best_cost_ff, best_cost_in;
   logic signed [CostW-1:0] second_cost_ff, second_cost_in;

   logic [DistW-1:0]   cur_dist;
   logic               far_from_best;
   logic [DistW-1:0]   lo_layer, hi_layer;
   logic [DistW-1:0]   best_w, second_w;
   logic [DispW-1:0]   offset;

   assign cur_dist      = index_dist(DistW'(best_layer_ff), DistW'(layer_ff));
   assign far_from_best = cur_dist > cfg.separation;

   always_comb begin
      best_layer_in   = best_layer_ff;
      best_cost_in    = best_cost_ff;
      second_layer_in = second_layer_ff;
      second_cost_in  = second_cost_ff;
      if (layer_ff == '0) begin
         best_layer_in   = '0;
         best_cost_in    = item.cost;
         second_layer_in = '0;
         second_cost_in  = item.cost;
      end else if (layer_ff == LayerW'(1)) begin
         // A tie between the two seed layers goes to layer one.
         if (best_cost_ff < item.cost) begin
            second_layer_in = layer_ff;
            second_cost_in  = item.cost;
         end else begin
            second_layer_in = best_layer_ff;
            second_cost_in  = best_cost_ff;
            best_layer_in   = layer_ff;
            best_cost_in    = item.cost;
         end
      end else begin
         if (item.cost < best_cost_ff) begin
            if (far_from_best) begin
               second_layer_in = best_layer_ff;
               second_cost_in  = best_cost_ff;
            end
            best_layer_in = layer_ff;
            best_cost_in  = item.cost;
         end else if (item.cost < second_cost_ff && far_from_best) begin
            second_layer_in = layer_ff;
            second_cost_in  = item.cost;
         end
      end
   end

   // The index saturates at the top layer until the run ends.
   always_comb begin
      if (item.last) begin
         layer_in = '0;
      end else if (layer_ff == LastLayer) begin
         layer_in = layer_ff;
      end else begin
         layer_in = layer_ff + LayerW'(1);
      end
   end

   assign best_w   = DistW'(best_layer_in);
   assign second_w = DistW'(second_layer_in);

   always_comb begin
      if (index_dist(best_w, second_w) <= cfg.merge_distance) begin
         lo_layer = best_w;
         hi_layer = best_w;
      end else if (best_w < second_w) begin
         lo_layer = best_w;
         hi_layer = second_w;
      end else begin
         lo_layer = second_w;
         hi_layer = best_w;
      end
   end

   assign offset           = {cfg.min_disp[OffsetW-1], cfg.min_disp};
   assign result.disp_low  = {2'b00, lo_layer} + offset;
   assign result.disp_high = {2'b00, hi_layer} + offset;

   always_ff @(posedge clock) begin
      if (reset) begin
         layer_ff        <= '0;
         best_layer_ff   <= '0;
         best_cost_ff    <= '0;
         second_layer_ff <= '0;
         second_cost_ff  <= '0;
      end else if (step) begin
         layer_ff        <= layer_in;
         best_layer_ff   <= best_layer_in;
         best_cost_ff    <= best_cost_in;
         second_layer_ff <= second_layer_in;
         second_cost_ff  <= second_cost_in;
      end
   end

endmodule

### tb/disparity_two_minima_range_core_tb.sv
module disparity_two_minima_range_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import dtm_pkg::*;

   localparam int CycleLimit = 400000;
   localparam int DrainCycles = 8;
   localparam int LongHoldCycles = 300;

   // Tracks the best and second-best layers of the pixel in flight and keeps
   // the disparity pairs that the block still owes.
   class disparity_scoreboard;
      logic signed [OffsetW-1:0] min_disp;
      logic [DistW-1:0]          separation;
      logic [DistW-1:0]          merge_distance;
      logic [DistW-1:0]          layer_index;
      logic [DistW-1:0]          best_layer;
      logic [DistW-1:0]          second_layer;
      logic signed [CostW-1:0]   best_cost;
      logic signed [CostW-1:0]   second_cost;
      result_type                pending_pairs[$];
      int                        errors;

      function new();
         min_disp = MinDispReset;
         separation = SeparationReset;
         merge_distance = MergeDistanceReset;
         layer_index = '0;
         best_layer = '0;
         second_layer = '0;
         best_cost = '0;
         second_cost = '0;
         errors = 0;
      endfunction

      function void write_reg(logic [CsrIdxW-1:0] idx, logic [CsrW-1:0] value);
         case (idx)
            CsrMinDisp:       min_disp = value[OffsetW-1:0];
            CsrSeparation:    separation = value[DistW-1:0];
            CsrMergeDistance: merge_distance = value[DistW-1:0];
            default: ;
         endcase
      endfunction

      function int layer_span(logic [DistW-1:0] a, logic [DistW-1:0] b);
         int ia;
         int ib;
         ia = int'(a);
         ib = int'(b);
         return (ia > ib) ? ia - ib : ib - ia;
      endfunction

      function void note_layer(logic signed [CostW-1:0] cost, logic last_layer);
         logic [DistW-1:0] idx;
         int               low_i;
         int               high_i;
         int               offset;
         result_type       pair;
         idx = layer_index;
         if (idx == '0) begin
            best_layer = '0;
            best_cost = cost;
            second_layer = '0;
            second_cost = cost;
         end else if (idx == DistW'(1)) begin
            // A tie between the two seed layers goes to layer 1.
            if (best_cost < cost) begin
               second_layer = DistW'(1);
               second_cost = cost;
            end else begin
               second_layer = best_layer;
               second_cost = best_cost;
               best_layer = DistW'(1);
               best_cost = cost;
            end
         end else if (cost < best_cost) begin
            if (layer_span(best_layer, idx) > int'(separation)) begin
               second_layer = best_layer;
               second_cost = best_cost;
            end
            best_layer = idx;
            best_cost = cost;
         end else if (cost < second_cost && layer_span(best_layer, idx) > int'(separation)) begin
            second_layer = idx;
            second_cost = cost;
         end

         if (!last_layer) begin
            // The layer count saturates at the top layer.
            if (layer_index != DistW'(MaxLayersDefault - 1))
               layer_index = layer_index + DistW'(1);
            return;
         end

         layer_index = '0;
         if (layer_span(best_layer, second_layer) <= int'(merge_distance)) begin
            low_i = int'(best_layer);
            high_i = int'(best_layer);
         end else if (best_layer < second_layer) begin
            low_i = int'(best_layer);
            high_i = int'(second_layer);
         end else begin
            low_i = int'(second_layer);
            high_i = int'(best_layer);
         end
         offset = int'(min_disp);
         pair.disp_low = DispW'(low_i + offset);
         pair.disp_high = DispW'(high_i + offset);
         pending_pairs.push_back(pair);
      endfunction

      function void check_result(logic [23:0] data);
         result_type got;
         result_type want;
         got = data[2*DispW-1:0];
         if (pending_pairs.size() == 0) begin
            $display("%0t: unexpected result low %0d high %0d", $time,
                     got.disp_low, got.disp_high);
            errors++;
            return;
         end
         want = pending_pairs.pop_front();
         if (got.disp_low !== want.disp_low) begin
            $display("%0t: disp_low expected %0d actual %0d", $time,
                     want.disp_low, got.disp_low);
            errors++;
         end
         if (got.disp_high !== want.disp_high) begin
            $display("%0t: disp_high expected %0d actual %0d", $time,
                     want.disp_high, got.disp_high);
            errors++;
         end
      endfunction
   endclass

   logic               clock;
   logic               reset;
   logic               req_tvalid;
   logic               req_tready;
   logic [15:0]        req_tdata;
   logic               req_tlast;
   logic               rsp_tvalid;
   logic               rsp_tready;
   logic [23:0]        rsp_tdata;
   logic               csr_we;
   logic [CsrIdxW-1:0] csr_index;
   logic [CsrW-1:0]    csr_wdata;

   disparity_scoreboard sb;
   int                  layers_sent;
   int                  results_seen;
   int                  cycle_count;
   int                  hold_left;
   bit                  idle_on;
   bit                  long_hold_done;

   disparity_two_minima_range_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #5 clock = ~clock;

   initial begin
      cycle_count = 0;
      while (cycle_count < CycleLimit) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("disparity_two_minima_range_core_tb: done, errors");
      $finish;
   end

   // Result side: checks every transaction, stalls in bursts, and once holds
   // off long enough for the block to back up into its input.
   initial begin
      rsp_tready = 1'b0;
      hold_left = 0;
      long_hold_done = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) begin
            sb.check_result(rsp_tdata);
            results_seen++;
         end
         if (!long_hold_done && results_seen >= 15) begin
            long_hold_done = 1'b1;
            hold_left = LongHoldCycles;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (idle_on && $urandom_range(0, 5) == 0) begin
            hold_left = $urandom_range(1, 7) - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   task automatic send_layer(input logic signed [CostW-1:0] cost, input logic last_layer);
      if (idle_on && $urandom_range(0, 4) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= cost;
      req_tlast <= last_layer;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_layer(cost, last_layer);
      layers_sent++;
   endtask

   function automatic logic signed [CostW-1:0] pick_cost(int mode);
      case (mode)
         0: return CostW'($urandom);
         1: return CostW'($urandom_range(0, 7));
         2: begin
            case ($urandom_range(0, 3))
               0: return 16'sh8000;
               1: return 16'sh7fff;
               2: return 16'sd0;
               default: return -16'sd1;
            endcase
         end
         default: return CostW'($urandom_range(0, 400)) - 16'sd200;
      endcase
   endfunction

   task automatic send_pixel(input int layers);
      int mode;
      mode = $urandom_range(0, 3);
      idle_on = idle_on && ($urandom_range(0, 3) != 0) || (idle_on && 1'b0);
      for (int i = 0; i < layers; i++)
         send_layer(pick_cost(mode), i == layers - 1);
   endtask

   // Lets every pending pair arrive and the pipeline empty before registers move.
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (sb.pending_pairs.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
   endtask

   task automatic configure(input int offset, input int sep, input int merge_dist);
      csr_we <= 1'b1;
      csr_index <= CsrMinDisp;
      csr_wdata <= CsrW'(offset);
      @(posedge clock);
      sb.write_reg(CsrMinDisp, CsrW'(offset));
      csr_index <= CsrSeparation;
      csr_wdata <= CsrW'(sep);
      @(posedge clock);
      sb.write_reg(CsrSeparation, CsrW'(sep));
      csr_index <= CsrMergeDistance;
      csr_wdata <= CsrW'(merge_dist);
      @(posedge clock);
      sb.write_reg(CsrMergeDistance, CsrW'(merge_dist));
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   task automatic random_phase(input int target, input bit busy, input bit with_long);
      int goal;
      int pick;
      goal = layers_sent + target;
      if (with_long) begin
         idle_on = busy;
         send_pixel(MaxLayersDefault + $urandom_range(0, 60));
      end
      while (layers_sent < goal) begin
         idle_on = busy && ($urandom_range(0, 3) != 0);
         pick = $urandom_range(0, 99);
         if (pick < 70)
            send_pixel($urandom_range(1, 12));
         else
            send_pixel($urandom_range(13, 40));
      end
      drain();
   endtask

   initial begin
      sb = new();
      clock = 1'b0;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tlast = 1'b0;
      csr_we = 1'b0;
      csr_index = CsrMinDisp;
      csr_wdata = '0;
      layers_sent = 0;
      results_seen = 0;
      idle_on = 1'b1;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed pixels under the reset register values.
      send_layer(16'sh7fff, 1'b1);
      send_layer(16'sd100, 1'b0);
      send_layer(16'sd100, 1'b1);
      send_layer(16'sh8000, 1'b0);
      send_layer(16'sh7fff, 1'b1);
      // Far new best pushes the old best into second place.
      send_layer(16'sd0, 1'b0);
      for (int i = 1; i < 7; i++) send_layer(16'sd30, 1'b0);
      send_layer(16'sh8000, 1'b1);
      // Near layers below the second best do not replace it; an equal cost does not take the best.
      send_layer(16'sd10, 1'b0);
      send_layer(16'sd20, 1'b0);
      send_layer(16'sd10, 1'b0);
      send_layer(16'sd15, 1'b0);
      send_layer(16'sd20, 1'b1);
      // A near new best leaves the second best alone and the pair merges.
      send_layer(16'sd50, 1'b0);
      send_layer(16'sd60, 1'b0);
      send_layer(16'sd40, 1'b1);
      drain();

      configure(-256, 0, 0);
      random_phase(400, 1'b1, 1'b1);
      configure(255, 255, 255);
      random_phase(300, 1'b1, 1'b0);
      configure($urandom_range(0, 511) - 256, $urandom_range(0, 10), $urandom_range(0, 4));
      random_phase(400, 1'b1, 1'b0);
      configure(17, 3, 2);
      random_phase(400, 1'b1, 1'b1);
      configure($urandom_range(0, 511) - 256, $urandom_range(0, 255), $urandom_range(0, 255));
      random_phase(400, 1'b0, 1'b0);

      if (sb.errors == 0 && sb.pending_pairs.size() == 0)
         $display("disparity_two_minima_range_core_tb: done, clean");
      else
         $display("disparity_two_minima_range_core_tb: done, errors");
      $finish;
   end

endmodule
